// ===== hdl/lrrw_pkg.sv =====
// Shared constants, types and helper functions for the log request-rate window block.
package lrrw_pkg;

  localparam int RING_DEPTH = 1024;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int FILL_W     = $clog2(RING_DEPTH + 1);

  localparam int IN_W  = 56;
  localparam int OUT_W = 88;

  localparam logic [11:0] EPOCH_YEAR         = 12'd1970;
  localparam logic [10:0] LEAPS_BEFORE_EPOCH = 11'd477;
  localparam logic [12:0] RECIP_100          = 13'd5243;
  localparam int          RECIP_SHIFT        = 19;
  localparam logic [19:0] DAYS_PER_YEAR      = 20'd365;
  localparam logic [18:0] SECS_PER_HOUR      = 19'd3600;
  localparam logic [18:0] SECS_PER_MIN       = 19'd60;
  localparam logic signed [39:0] SECS_PER_DAY = 40'sd86400;
  localparam logic signed [39:0] TS_MAX      = 40'sd4294967295;
  localparam logic signed [39:0] TS_MIN      = -40'sd4294967296;
  localparam logic [15:0] GAP_RESET          = 16'd10;
  localparam logic [3:0]  SERVER_ERROR_CLASS = 4'd5;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LEAP,
    S_DAYS,
    S_MUL,
    S_SAT,
    S_PUSH,
    S_RD,
    S_CMP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic push;
    logic rd;
    logic pop;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pop_ok;
    logic out_busy;
  } dp_stat_t;

  // days before the first of the month; months past December count as December
  function automatic logic [8:0] cum_days(input logic [3:0] mon);
    logic [8:0] d;
    case (mon)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      default: d = 9'd334;
    endcase
    return d;
  endfunction

  function automatic logic [RING_AW-1:0] ring_next(input logic [RING_AW-1:0] p);
    return (p == RING_AW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

// ===== hdl/log_request_rate_window.sv =====
// Top level of the log request-rate window block: controller plus datapath.
// Each record transfer is converted to seconds since 1970 (calendar with leap years, zone
// offset applied, saturated to 33-bit signed), pushed into a 1024-entry timestamp ring, and
// old entries are popped while the span exceeds gap_seconds. Each record passes through the
// accept state, the conversion pipeline states (leap, days, multiply, saturate), one push,
// a read-then-compare pair for each ring entry examined on the single memory read port, and
// a state that loads the output register; a new record is accepted only once that is done.
// A finished result sits in the output register while the next record is taken in; the block
// stalls only when a second result is ready before the first is taken.
module log_request_rate_window (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // day_of_month[4:0], month_index[8:5], year[20:9], hour[25:21], minute[31:26],
  // second[37:32], zone_negative[38], zone_hours[42:39], zone_minutes[48:43],
  // status_class[52:49], zero fill[55:53]
  input  logic [lrrw_pkg::IN_W-1:0]     in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // timestamp_seconds[32:0], server_error_count[64:33], window_count[75:65],
  // max_window_count[86:76], ring_overflow[87]
  output logic [lrrw_pkg::OUT_W-1:0]    out_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [15:0]                   cfg_data
);
  import lrrw_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  lrrw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lrrw_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== hdl/lrrw_ctrl.sv =====
// Controller state machine sequencing conversion, ring push, pops and result hand-off.
module lrrw_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  lrrw_pkg::dp_stat_t   stat,
  output lrrw_pkg::ctrl_cmd_t  cmd
);
  import lrrw_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_LEAP;
      S_LEAP: state_nxt = S_DAYS;
      S_DAYS: state_nxt = S_MUL;
      S_MUL:  state_nxt = S_SAT;
      S_SAT:  state_nxt = S_PUSH;
      S_PUSH: state_nxt = S_RD;
      S_RD:   state_nxt = S_CMP;
      S_CMP:  state_nxt = stat.pop_ok ? S_RD : S_DONE;
      S_DONE: if (!stat.out_busy) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      S_PUSH: cmd.push = 1'b1;
      S_RD:   cmd.rd   = 1'b1;
      S_CMP:  cmd.pop  = stat.pop_ok;
      S_DONE: cmd.emit = !stat.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== hdl/lrrw_dp.sv =====
// Datapath: timestamp conversion pipeline, timestamp ring memory, counters and result register.
module lrrw_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [lrrw_pkg::IN_W-1:0]     in_tdata,
  input  logic                          cfg_valid,
  input  logic [15:0]                   cfg_data,
  input  lrrw_pkg::ctrl_cmd_t           cmd,
  output lrrw_pkg::dp_stat_t            stat,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [lrrw_pkg::OUT_W-1:0]    out_tdata
);
  import lrrw_pkg::*;

  logic [4:0]  day_r;
  logic [3:0]  mon_r;
  logic [11:0] year_r;
  logic [4:0]  hr_r;
  logic [5:0]  min_r;
  logic [5:0]  sec_r;
  logic        zneg_r;
  logic [3:0]  zh_r;
  logic [5:0]  zm_r;
  logic [3:0]  cls_r;

  logic [5:0]               q_r;
  logic signed [21:0]       days_r;
  logic signed [39:0]       prod_r;
  logic signed [18:0]       tod_r;
  logic signed [32:0]       ts_r;
  logic signed [32:0]       rd_r;
  logic signed [32:0]       ring_mem [RING_DEPTH];

  logic [RING_AW-1:0] head_r, tail_r;
  logic [FILL_W-1:0]  fill_r, best_r;
  logic [31:0]        err_r;
  logic               ovf_r;
  logic [15:0]        gap_r;
  logic               out_valid_r;

  logic [32:0] out_ts_r;
  logic [31:0] out_err_r;
  logic [10:0] out_win_r;
  logic [10:0] out_max_r;
  logic        out_ovf_r;

  logic [11:0]        yprev;
  logic [24:0]        quo_prod;
  logic [10:0]        leaps;
  logic [11:0]        whole;
  logic [19:0]        ydays;
  logic signed [21:0] days_nxt;
  logic [18:0]        clk_secs;
  logic [18:0]        off_secs;
  logic signed [39:0] days_ext;
  logic signed [39:0] sum;
  logic signed [32:0] ts_nxt;
  logic signed [33:0] span;
  logic signed [33:0] gap_ext;
  logic               full;
  logic [FILL_W-1:0]  best_nxt;

  always_comb begin
    yprev    = year_r - 12'd1;
    quo_prod = 25'(yprev) * 25'(RECIP_100);
    leaps    = 11'(yprev[11:2]) - 11'(q_r) + 11'(q_r[5:2]) - LEAPS_BEFORE_EPOCH;
    whole    = year_r - EPOCH_YEAR;
    ydays    = (year_r > EPOCH_YEAR) ? 20'(whole) * DAYS_PER_YEAR + 20'(leaps) : 20'd0;
    days_nxt = $signed(22'(ydays) + 22'(cum_days(mon_r)) + 22'(day_r) - 22'd1);
    clk_secs = 19'(hr_r) * SECS_PER_HOUR + 19'(min_r) * SECS_PER_MIN + 19'(sec_r);
    off_secs = 19'(zh_r) * SECS_PER_HOUR + 19'(zm_r) * SECS_PER_MIN;
    days_ext = 40'(days_r);
    sum      = prod_r + 40'(tod_r);
    if (sum > TS_MAX) begin
      ts_nxt = TS_MAX[32:0];
    end else if (sum < TS_MIN) begin
      ts_nxt = TS_MIN[32:0];
    end else begin
      ts_nxt = sum[32:0];
    end
    span     = 34'(ts_r) - 34'(rd_r);
    gap_ext  = $signed({18'd0, gap_r});
    full     = (fill_r == FILL_W'(RING_DEPTH));
    best_nxt = (fill_r > best_r) ? fill_r : best_r;
  end

  assign stat.pop_ok   = (span > gap_ext);
  assign stat.out_busy = out_valid_r && !out_tready;

  // input capture and conversion pipeline
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      day_r  <= in_tdata[4:0];
      mon_r  <= in_tdata[8:5];
      year_r <= in_tdata[20:9];
      hr_r   <= in_tdata[25:21];
      min_r  <= in_tdata[31:26];
      sec_r  <= in_tdata[37:32];
      zneg_r <= in_tdata[38];
      zh_r   <= in_tdata[42:39];
      zm_r   <= in_tdata[48:43];
      cls_r  <= in_tdata[52:49];
    end
    q_r    <= quo_prod[24:RECIP_SHIFT];
    days_r <= days_nxt;
    prod_r <= days_ext * SECS_PER_DAY;
    tod_r  <= zneg_r ? $signed(clk_secs - off_secs) : $signed(clk_secs + off_secs);
    ts_r   <= ts_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      ring_mem[head_r] <= ts_r;
    end
    if (cmd.rd) begin
      rd_r <= ring_mem[tail_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      best_r      <= '0;
      err_r       <= '0;
      ovf_r       <= 1'b0;
      gap_r       <= GAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        gap_r <= cfg_data;
      end
      if (cmd.push) begin
        head_r <= ring_next(head_r);
        ovf_r  <= full;
        if (full) begin
          tail_r <= ring_next(tail_r);
        end else begin
          fill_r <= fill_r + 1'b1;
        end
        if (cls_r == SERVER_ERROR_CLASS && err_r != '1) begin
          err_r <= err_r + 32'd1;
        end
      end
      if (cmd.pop) begin
        tail_r <= ring_next(tail_r);
        fill_r <= fill_r - 1'b1;
      end
      if (cmd.emit) begin
        best_r      <= best_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_ts_r  <= ts_r;
      out_err_r <= err_r;
      out_win_r <= 11'(fill_r);
      out_max_r <= 11'(best_nxt);
      out_ovf_r <= ovf_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_ovf_r, out_max_r, out_win_r, out_err_r, out_ts_r};

endmodule
